@@ src/olist_pkg.sv @@
// ordered list engine: shared constants, command and status codes, memory request type
// no dependencies

package olist_pkg;

	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 3;
	localparam int VAL_W    = 8;
	localparam int FIELD_W  = 8;
	localparam int STAT_W   = 2;
	localparam int CMP_W    = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
	} mem_req_t;

endpackage

@@ src/olist_if.sv @@
// ordered list engine: command and response channel interfaces
// depends on olist_pkg

interface olist_cmd_if
	import olist_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [VAL_W-1:0]    value;
	logic [FIELD_W-1:0]  position;

	modport source (output valid, func, value, position, input ready);
	modport sink (input valid, func, value, position, output ready);
endinterface

interface olist_rsp_if
	import olist_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [FIELD_W-1:0]  found_position;
	logic [FIELD_W-1:0]  list_length;

	modport source (output valid, status, found_position, list_length, input ready);
	modport sink (input valid, status, found_position, list_length, output ready);
endinterface

@@ src/olist_ram.sv @@
// ordered list engine: entry store, one write and one registered read per cycle
// depends on olist_pkg

module olist_ram
	import olist_pkg::*;
(
	input  logic             clk,
	input  mem_req_t         req,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

@@ src/olist_ctrl.sv @@
// ordered list engine: command sequencer, walks the entry store for shift and search
// depends on olist_pkg, olist_if and the registered read of the entry store

module olist_ctrl
	import olist_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	olist_cmd_if.sink        cmd,
	olist_rsp_if.source      rsp,
	output mem_req_t         mem_req,
	input  logic [VAL_W-1:0] rd_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FINAL = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic               vld_s1;
	logic               out_valid_q;

	logic [FUNC_W-1:0]  op_q;
	logic [VAL_W-1:0]   value_q;
	logic [IDX_W-1:0]   pidx_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   end_q;
	logic [IDX_W-1:0]   addr_s1;
	logic [STAT_W-1:0]  status_q;
	logic [FIELD_W-1:0] found_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic [FIELD_W-1:0] rsp_found_q;
	logic [FIELD_W-1:0] rsp_length_q;

	logic               accept;
	logic               full;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   cnt_ext;
	logic               ins_bad;
	logic               rem_bad;
	logic               ins_at_end;
	logic [IDX_W-1:0]   pidx;
	logic [IDX_W-1:0]   cidx;
	logic               match;
	logic               rsp_load;
	logic [STAT_W-1:0]  new_status;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == S_IDLE);
	assign full       = (count_q >= CNT_W'(CAPACITY));
	assign pos_ext    = CMP_W'(cmd.position);
	assign cnt_ext    = CMP_W'(count_q);
	assign ins_bad    = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
	assign rem_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
	assign ins_at_end = (pos_ext == cnt_ext + CMP_W'(1));
	assign pidx       = IDX_W'(cmd.position - FIELD_W'(1));
	assign cidx       = count_q[IDX_W-1:0];
	assign match      = (rd_data == value_q);
	assign rsp_load   = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.found_position = rsp_found_q;
	assign rsp.list_length    = rsp_length_q;

	always_comb begin
		if ((cmd.func == FN_APPEND || cmd.func == FN_INSERT) && full) begin
			new_status = STATUS_FULL;
		end else if ((cmd.func == FN_INSERT && ins_bad) || (cmd.func == FN_REMOVE && rem_bad)) begin
			new_status = STATUS_RANGE;
		end else begin
			new_status = STATUS_OK;
		end
	end

	// reads walk away from the entries being rewritten, so no forwarding is needed
	always_comb begin
		mem_req.re    = (state_q == S_WALK);
		mem_req.raddr = ptr_q;
		mem_req.we    = 1'b0;
		mem_req.waddr = cidx;
		mem_req.wdata = cmd.value;
		if (state_q == S_IDLE) begin
			mem_req.we = accept && !full && ((cmd.func == FN_APPEND) ||
				(cmd.func == FN_INSERT && ins_at_end));
		end else if (state_q == S_FINAL) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = pidx_q;
			mem_req.wdata = value_q;
		end else if (vld_s1 && (op_q == FN_INSERT || op_q == FN_REMOVE)) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = (op_q == FN_INSERT) ? addr_s1 + IDX_W'(1) : addr_s1 - IDX_W'(1);
			mem_req.wdata = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
						unique case (cmd.func)
							FN_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							FN_INSERT: begin
								if (!full && !ins_bad) begin
									if (ins_at_end) begin
										count_q <= count_q + CNT_W'(1);
									end else begin
										state_q <= S_WALK;
									end
								end
							end
							FN_REMOVE: begin
								if (!rem_bad) begin
									if (pos_ext == cnt_ext) begin
										count_q <= count_q - CNT_W'(1);
									end else begin
										state_q <= S_WALK;
									end
								end
							end
							FN_FIND: begin
								if (count_q != '0) begin
									state_q <= S_WALK;
								end
							end
							FN_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (vld_s1 && op_q == FN_FIND && match) begin
						vld_s1  <= 1'b0;
						state_q <= S_RESP;
					end else begin
						vld_s1 <= 1'b1;
						if (ptr_q == end_q) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					vld_s1 <= 1'b0;
					if (op_q == FN_INSERT) begin
						state_q <= S_FINAL;
					end else begin
						if (op_q == FN_REMOVE) begin
							count_q <= count_q - CNT_W'(1);
						end
						state_q <= S_RESP;
					end
				end
				S_FINAL: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= cmd.func;
			value_q  <= cmd.value;
			pidx_q   <= pidx;
			status_q <= new_status;
			found_q  <= '0;
			priority case (cmd.func)
				FN_INSERT: begin
					ptr_q <= cidx - IDX_W'(1);
					end_q <= pidx;
				end
				FN_REMOVE: begin
					ptr_q <= pidx + IDX_W'(1);
					end_q <= cidx - IDX_W'(1);
				end
				default: begin
					ptr_q <= '0;
					end_q <= cidx - IDX_W'(1);
				end
			endcase
		end
		if (state_q == S_WALK) begin
			addr_s1 <= ptr_q;
			ptr_q   <= (op_q == FN_INSERT) ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
		end
		if (vld_s1 && op_q == FN_FIND && match && found_q == '0) begin
			found_q <= FIELD_W'(CMP_W'(addr_s1) + CMP_W'(1));
		end
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_length_q <= FIELD_W'(count_q);
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.re && mem_req.we) |-> (mem_req.raddr != mem_req.waddr))
		else $error("read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.func == FN_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the list");

	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_WALK || state_q == S_DRAIN))
		else $error("read stage active outside a walk");

endmodule

@@ src/ordered_list_engine_top.sv @@
// ordered list engine top level: command sequencer and entry store
// depends on olist_pkg, olist_if, olist_ram and olist_ctrl
//
// Keeps an ordered list of up to CAPACITY bytes and answers each command transaction with
// one response transaction. One command is worked at a time. Append, clear, rejected
// commands, find on an empty list, insert at the end and remove of the last entry need no
// walk and go straight from accept to the response state. Insert at position p walks length-p+1
// entries, remove at p walks length-p entries and find walks up to its first match or
// length entries, one entry per cycle through the entry store (one read and one write per
// cycle). A stalled response holds the next one back.
// The entry store needs no clearing after reset; only entries below the length are read.

module ordered_list_engine_top
	import olist_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	olist_cmd_if.sink   cmd,
	olist_rsp_if.source rsp
);

	mem_req_t         mem_req;
	logic [VAL_W-1:0] rd_data;

	olist_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	olist_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

@@ tb/olist_checker.sv @@
`timescale 1ns / 1ps
// ordered list engine checker: watches the command and response channels, keeps its own
// copy of the list and compares each response transaction with the predicted one
// depends on olist_pkg and olist_if

module olist_checker
	import olist_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	olist_cmd_if  cmd,
	olist_rsp_if  rsp,
	output int    error_count,
	output int    outstanding,
	output int    entries
);

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIELD_W-1:0] found_position;
		logic [FIELD_W-1:0] list_length;
	} list_reply_t;

	logic [VAL_W-1:0] shadow_list [CAPACITY];
	int               shadow_len;
	list_reply_t      pending_replies [$];

	function automatic list_reply_t apply_command(logic [FUNC_W-1:0] func,
		logic [VAL_W-1:0] value, logic [FIELD_W-1:0] position);
		list_reply_t reply;
		int          pos;
		int          i;
		reply = '0;
		reply.status = STATUS_OK;
		pos = position;
		case (func)
		FN_APPEND: begin
			if (shadow_len >= CAPACITY) begin
				reply.status = STATUS_FULL;
			end else begin
				shadow_list[shadow_len] = value;
				shadow_len++;
			end
		end
		FN_INSERT: begin
			if (shadow_len >= CAPACITY) begin
				reply.status = STATUS_FULL;
			end else if (pos < 1 || pos > shadow_len + 1) begin
				reply.status = STATUS_RANGE;
			end else begin
				for (i = shadow_len; i >= pos; i--)
					shadow_list[i] = shadow_list[i - 1];
				shadow_list[pos - 1] = value;
				shadow_len++;
			end
		end
		FN_REMOVE: begin
			if (pos < 1 || pos > shadow_len) begin
				reply.status = STATUS_RANGE;
			end else begin
				for (i = pos; i < shadow_len; i++)
					shadow_list[i - 1] = shadow_list[i];
				shadow_len--;
			end
		end
		FN_FIND: begin
			for (i = 0; i < shadow_len; i++) begin
				if (reply.found_position == '0 && shadow_list[i] == value)
					reply.found_position = FIELD_W'(i + 1);
			end
		end
		FN_CLEAR: begin
			shadow_len = 0;
		end
		default: begin
		end
		endcase
		reply.list_length = FIELD_W'(shadow_len);
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		if (!arst_n) begin
			shadow_len = 0;
			pending_replies.delete();
			error_count = 0;
			outstanding = 0;
			entries = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected response status %0d found %0d length %0d",
						$time, rsp.status, rsp.found_position, rsp.list_length);
					error_count++;
				end else begin
					want = pending_replies.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp.status);
						error_count++;
					end
					if (rsp.found_position !== want.found_position) begin
						$display("%0t: found_position mismatch: expected %0d, actual %0d",
							$time, want.found_position, rsp.found_position);
						error_count++;
					end
					if (rsp.list_length !== want.list_length) begin
						$display("%0t: list_length mismatch: expected %0d, actual %0d",
							$time, want.list_length, rsp.list_length);
						error_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				pending_replies.push_back(apply_command(cmd.func, cmd.value, cmd.position));
			outstanding = pending_replies.size();
			entries = shadow_len;
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ordered list engine testbench top: clock, reset, command stimulus and response stalls
// depends on olist_pkg, olist_if, ordered_list_engine_top and olist_checker

module tb_top;
	import olist_pkg::*;

	localparam int ITEM_TARGET = 900;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_WAIT  = CAPACITY + 8;

	typedef enum {SEG_MIX, SEG_FILL, SEG_DRAIN} segment_t;

	logic clk;
	logic arst_n;
	int   error_count;
	int   outstanding;
	int   entries;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   items_sent;
	int   quiet_cycles;

	olist_cmd_if cmd();
	olist_rsp_if rsp();

	ordered_list_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	olist_checker list_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.error_count (error_count),
		.outstanding (outstanding),
		.entries     (entries)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

	task automatic send_command(logic [FUNC_W-1:0] func, logic [VAL_W-1:0] value,
		logic [FIELD_W-1:0] position);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid = 1'b0;
			@(negedge clk);
		end
		cmd.valid    = 1'b1;
		cmd.func     = func;
		cmd.value    = value;
		cmd.position = position;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(1))
			return VAL_W'($urandom_range(15));
		return VAL_W'($urandom_range(255));
	endfunction

	// last_ok is the highest legal position, 0 when none is legal
	function automatic logic [FIELD_W-1:0] pick_position(int last_ok, int bad_pct);
		int roll;
		roll = $urandom_range(99);
		if (last_ok == 0 || roll < bad_pct) begin
			if ($urandom_range(2) == 0)
				return '0;
			return FIELD_W'($urandom_range(last_ok + 1, 255));
		end
		if (roll < bad_pct + 12)
			return FIELD_W'(1);
		if (roll < bad_pct + 24)
			return FIELD_W'(last_ok);
		return FIELD_W'($urandom_range(1, last_ok));
	endfunction

	task automatic issue_random(segment_t kind);
		int                 roll;
		int                 bad_pct;
		logic [FUNC_W-1:0]  func;
		logic [FIELD_W-1:0] position;
		roll = $urandom_range(99);
		bad_pct = (kind == SEG_MIX) ? 12 : 3;
		case (kind)
		SEG_FILL:  func = (roll < 45) ? FN_APPEND : (roll < 90) ? FN_INSERT : FN_FIND;
		SEG_DRAIN: func = (roll < 85) ? FN_REMOVE : FN_FIND;
		default: begin
			if (roll < 20)
				func = FN_APPEND;
			else if (roll < 45)
				func = FN_INSERT;
			else if (roll < 70)
				func = FN_REMOVE;
			else if (roll < 92)
				func = FN_FIND;
			else if (roll < 96)
				func = FN_CLEAR;
			else
				func = FUNC_W'($urandom_range(FN_CLEAR + 1, (1 << FUNC_W) - 1));
		end
		endcase
		if (func == FN_INSERT && entries < CAPACITY)
			position = pick_position(entries + 1, bad_pct);
		else if (func == FN_REMOVE)
			position = pick_position(entries, bad_pct);
		else
			position = FIELD_W'($urandom_range(255));
		send_command(func, pick_value(), position);
	endtask

	task automatic run_segment(segment_t kind);
		case (kind)
		SEG_FILL: begin
			while (entries < CAPACITY)
				issue_random(SEG_FILL);
			// three to six more fill commands, mostly growth attempts, against the full list
			repeat ($urandom_range(3, 6))
				issue_random(SEG_FILL);
		end
		SEG_DRAIN: begin
			while (entries > 0)
				issue_random(SEG_DRAIN);
			repeat ($urandom_range(1, 3))
				issue_random(SEG_DRAIN);
		end
		default: begin
			repeat ($urandom_range(20, 60))
				issue_random(SEG_MIX);
		end
		endcase
	endtask

	initial begin
		int       idle_plan [4];
		int       stall_plan [4];
		int       phase;
		int       f;
		int       roll;
		segment_t kind;

		idle_plan  = '{0, 50, 0, 9};
		stall_plan = '{0, 0, 50, 9};
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.func       = FN_APPEND;
		cmd.value      = '0;
		cmd.position   = '0;
		rsp.ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		items_sent     = 0;
		quiet_cycles   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corner cases
		send_command(FN_FIND,   8'h00, 8'd0);
		send_command(FN_REMOVE, 8'h00, 8'd1);
		send_command(FN_REMOVE, 8'h00, 8'd0);
		send_command(FN_INSERT, 8'hFF, 8'd0);
		send_command(FN_INSERT, 8'hFF, 8'd2);
		// build a short list with a duplicate
		send_command(FN_INSERT, 8'h00, 8'd1);
		send_command(FN_APPEND, 8'hFF, 8'd0);
		send_command(FN_INSERT, 8'hAA, 8'd3);
		send_command(FN_INSERT, 8'h55, 8'd1);
		send_command(FN_INSERT, 8'hFF, 8'd3);
		send_command(FN_FIND,   8'hFF, 8'd0);
		send_command(FN_FIND,   8'hAA, 8'd0);
		send_command(FN_FIND,   8'h55, 8'd0);
		send_command(FN_FIND,   8'h12, 8'd0);
		// out of range positions
		send_command(FN_INSERT, 8'h01, 8'd255);
		send_command(FN_REMOVE, 8'h00, 8'd6);
		send_command(FN_REMOVE, 8'h00, 8'd255);
		// remove first, last and middle
		send_command(FN_REMOVE, 8'h00, 8'd1);
		send_command(FN_REMOVE, 8'h00, 8'd4);
		send_command(FN_REMOVE, 8'h00, 8'd2);
		for (f = FN_CLEAR + 1; f < (1 << FUNC_W); f++)
			send_command(FUNC_W'(f), 8'hFF, 8'hFF);
		send_command(FN_CLEAR, 8'h00, 8'd0);
		send_command(FN_FIND,  8'h00, 8'd0);

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct  = idle_plan[phase];
			recv_stall_pct = stall_plan[phase];
			if (phase % 2 == 0)
				run_segment(SEG_FILL);
			while (items_sent < (phase + 1) * ITEM_TARGET / 4) begin
				roll = $urandom_range(99);
				kind = (roll < 50) ? SEG_MIX : (roll < 75) ? SEG_FILL : SEG_DRAIN;
				run_segment(kind);
			end
		end

		cmd.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
